// ===== src/olst_pkg.sv =====
// Shared types and constants for the ordered list store.
// Used by olst_cell and ordered_list_store; no dependencies.
package olst_pkg;

  // Store geometry
  localparam int DEPTH  = 8;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Common width for comparing count, position and cell index
  localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;

  // Stream payload widths (packed, padded to whole bytes)
  localparam int IN_W   = 40;
  localparam int OUT_W  = 8;

  typedef enum logic [1:0] {
    ACT_FRONT  = 2'd0,
    ACT_BACK   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SEARCH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Per-cell control, driven by the top level each cycle
  typedef struct packed {
    logic live;        // cell holds a valid entry
    logic load_value;  // capture the command value
    logic take_left;   // shift toward the back
    logic take_right;  // shift toward the front
  } cell_ctrl_t;

endpackage

// ===== src/olst_cell.sv =====
// One storage cell of the ordered list store: holds one entry, shifts
// with its neighbors and compares against the command value.
// Depends on olst_pkg.
module olst_cell (
  input  logic                       clk,
  input  olst_pkg::cell_ctrl_t       ctrl,
  input  logic [olst_pkg::DATA_W-1:0] value,
  input  logic [olst_pkg::DATA_W-1:0] left_data,
  input  logic [olst_pkg::DATA_W-1:0] right_data,
  output logic [olst_pkg::DATA_W-1:0] data,
  output logic                       hit
);
  import olst_pkg::*;

  // Entry register; payload only, no reset
  always_ff @(posedge clk) begin
    if (ctrl.load_value) begin
      data <= value;
    end else if (ctrl.take_left) begin
      data <= left_data;
    end else if (ctrl.take_right) begin
      data <= right_data;
    end
  end

  // Full-width match, only on live entries
  assign hit = ctrl.live && (data == value);

endmodule

// ===== src/ordered_list_store.sv =====
// Top level of the ordered list store: command decode, entry count,
// a row of olst_cell instances and the result register.
// Depends on olst_pkg and olst_cell.
//
// Usage:
//   Commands arrive on the s_ channel, one per transfer: insert at front,
//   append at back, delete at a 1-based position, or search for a value.
//   Every command yields exactly one result transfer on the m_ channel
//   carrying status, found flag and the entry count after the command.
//   The result is valid the cycle after the command transfer. Throughput
//   is one command per cycle while results are taken; every cell compares
//   and shifts in the same cycle, so the row of cells sets the rate.
//   The result sits in an output register; s_tready stays high while that
//   register is empty or being taken, so a stalled receiver holds the
//   result and blocks further commands until it is taken.
//   Reset clears the entry count and the result valid; stored entries
//   are not cleared since entries at or past the count are never read.
//   Insert into a full store reports full, delete from an empty store
//   reports empty, a bad position reports out of range; all leave the
//   store unchanged.
module ordered_list_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata: [1:0] action, [33:2] value, [37:34] position, [39:38] zero
  input  logic [olst_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata: [1:0] status, [2] found, [6:3] count, [7] zero
  output logic [olst_pkg::OUT_W-1:0] m_tdata
);
  import olst_pkg::*;

  // Command fields
  action_t            action;
  logic [DATA_W-1:0]  value;
  logic [3:0]         position;
  logic               in_fire;

  assign action   = action_t'(s_tdata[1:0]);
  assign value    = s_tdata[33:2];
  assign position = s_tdata[37:34];
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // Entry count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] count_cmp;
  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] del_idx;
  logic             full;
  logic             empty;
  logic             pos_ok;

  assign count_cmp = CMP_W'(count);
  assign pos_cmp   = CMP_W'(position);
  assign del_idx   = pos_cmp - CMP_W'(1);
  assign full      = (count_cmp >= CMP_W'(DEPTH));
  assign empty     = (count == '0);
  assign pos_ok    = (pos_cmp != '0) && (pos_cmp <= count_cmp);

  // Command decode: status, what the store does, next count
  status_t status;
  logic    do_front;
  logic    do_back;
  logic    do_delete;

  always_comb begin
    status     = ST_OK;
    do_front   = 1'b0;
    do_back    = 1'b0;
    do_delete  = 1'b0;
    count_next = count;
    case (action)
      ACT_FRONT, ACT_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_front   = (action == ACT_FRONT);
          do_back    = (action == ACT_BACK);
          count_next = count + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          do_delete  = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Row of cells
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_hit;
  cell_ctrl_t        cell_ctrl [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;

    always_comb begin
      cell_ctrl[i].live       = (CMP_W'(i) < count_cmp);
      cell_ctrl[i].take_left  = in_fire && do_front;
      cell_ctrl[i].load_value = in_fire && do_back && (CMP_W'(i) == count_cmp);
      cell_ctrl[i].take_right = in_fire && do_delete && (CMP_W'(i) >= del_idx);
    end

    if (i == 0) begin : g_head
      assign left_in = value;
    end else begin : g_body
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_in = cell_data[i];
    end else begin : g_mid
      assign right_in = cell_data[i+1];
    end

    olst_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .value      (value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .hit        (cell_hit[i])
    );
  end

  logic found;
  assign found = (action == ACT_SEARCH) && (|cell_hit);

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // Result register
  logic [CMP_W-1:0] count_out;
  assign count_out = CMP_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {1'b0, count_out[3:0], found, status};
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_cmp <= CMP_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && (action == ACT_FRONT || action == ACT_BACK) && !full
    |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> m_tvalid)
    else $error("accepted command produced no result");

  a_found_search_only: assert property (@(posedge clk) disable iff (rst)
    in_fire && action != ACT_SEARCH |=> !m_tdata[2])
    else $error("found flag set on a non-search command");

endmodule
